// ===== hw/rtl/rau_pkg.sv =====
package rau_pkg;

  // Field widths of the channels
  localparam int unsigned NumW     = 32;
  localparam int unsigned DenW     = 31;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned DefValueW = 32;

  typedef enum logic [ModeW-1:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_CMP = 3'd4
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_REDUCE,
    S_GCD_START,
    S_GCD_WAIT,
    S_DIVN_START,
    S_DIVN_WAIT,
    S_DIVD_START,
    S_DIVD_WAIT,
    S_CHECK,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [ModeW-1:0]   mode;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [NumW-1:0] res_num;
    logic [DenW-1:0]        res_den;
    logic                   equal;
    logic [StatusW-1:0]     status;
  } out_t;

endpackage

// ===== hw/rtl/rau_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module rau_divider #(
  parameter int unsigned Width = 65
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             done_o,
  output logic [Width-1:0] quot_o,
  output logic [Width-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(Width + 1);

  logic [Width:0]   rem_q, rem_d;
  logic [Width-1:0] quo_q, quo_d;
  logic [Width-1:0] dvs_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [Width:0]   shifted, diff;

  // Shift in the next dividend bit and trial-subtract
  assign shifted = {rem_q[Width-1:0], quo_q[Width-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[Width]) begin
        rem_d = diff;
        quo_d = {quo_q[Width-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[Width-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(Width - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q[Width-1:0];

endmodule

// ===== hw/rtl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit.
// Input channel in_valid_i / in_stall_o carries one transaction: mode and two
// fractions a_num/a_den, b_num/b_den (low ValueW bits of each, sign-extended).
// Output channel out_valid_o / out_stall_i returns one result per transaction:
// reduced numerator, positive denominator, equal flag and status.
// Sequence: the cross products are formed in S_MUL1 and S_MUL2 (and S_MUL3 for add
// and subtract) on one shared ValueW x ValueW multiplier, then Euclid's loop runs
// each modulo step on a shared restoring divider of 2*ValueW+1 bits, then two
// more divider passes do the division by the gcd. Compare, zero-denominator
// and zero-numerator cases finish after the products. The length of a full
// reduction is set by the number of Euclid steps. One transaction is in work
// at a time; in_stall_o is high meanwhile.
// The result sits in an output register; a new transaction is accepted while
// it waits, and the next result holds until the receiver takes the first.
// While out_stall_i is high the output payload and valid hold.
// Reset clears the sequencer and the output valid; no result is pending.
module rational_arithmetic_unit #(
  parameter int unsigned ValueW = rau_pkg::DefValueW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rau_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rau_pkg::out_t out_data_o
);

  localparam int unsigned PW = 2 * ValueW;
  localparam int unsigned SW = 2 * ValueW + 1;
  localparam logic [SW-1:0] Limit = SW'(1) << (ValueW - 1);

  rau_pkg::state_e state_q, state_d;

  logic [rau_pkg::ModeW-1:0] mode_q;
  logic [ValueW-1:0] an_q, ad_q, bn_q, bd_q;
  logic              ans_q, ads_q, bns_q, bds_q;
  logic [PW-1:0]     p1_q, p2_q;
  logic              s1_q, s2_q;
  logic [SW-1:0]     num_q, den_q, x_q, y_q, n_q, d_q;
  logic              neg_q;
  rau_pkg::out_t     res_q, out_q;
  logic              out_valid_q;

  logic              accept, out_free;
  logic [ValueW-1:0] mul_a, mul_b;
  logic              mul_s;
  logic [PW-1:0]     prod;
  logic              e1, e2;
  logic [SW-1:0]     sum_mag;
  logic              sum_neg;
  logic              div_start, div_done;
  logic [SW-1:0]     div_dvd, div_dvs, div_quo, div_rem;
  logic [rau_pkg::NumW-1:0] n_ext;

  // Take the low ValueW bits of an operand as sign and magnitude
  function automatic logic [ValueW:0] to_sm(logic [31:0] raw);
    logic [ValueW-1:0] v;
    v = raw[ValueW-1:0];
    return {v[ValueW-1], v[ValueW-1] ? (~v + 1'b1) : v};
  endfunction

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Shared multiplier operand and sign selection
  always_comb begin
    mul_a = an_q;
    mul_b = bd_q;
    mul_s = ans_q ^ bds_q;
    case (state_q)
      rau_pkg::S_MUL1: begin
        if (mode_q == rau_pkg::MODE_MUL) begin
          mul_b = bn_q;
          mul_s = ans_q ^ bns_q;
        end
      end
      rau_pkg::S_MUL2: begin
        mul_a = ad_q;
        case (mode_q)
          rau_pkg::MODE_MUL: begin
            mul_b = bd_q;
            mul_s = ads_q ^ bds_q;
          end
          rau_pkg::MODE_SUB: begin
            mul_b = bn_q;
            mul_s = ads_q ^ ~bns_q;
          end
          default: begin
            mul_b = bn_q;
            mul_s = ads_q ^ bns_q;
          end
        endcase
      end
      rau_pkg::S_MUL3: begin
        mul_a = ad_q;
        mul_b = bd_q;
        mul_s = ads_q ^ bds_q;
      end
      default: ;
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);

  // Signed sum of the two cross products
  assign e1 = s1_q && (p1_q != '0);
  assign e2 = s2_q && (p2_q != '0);
  always_comb begin
    if (e1 == e2) begin
      sum_mag = SW'(p1_q) + SW'(p2_q);
      sum_neg = e1;
    end else if (p1_q >= p2_q) begin
      sum_mag = SW'(p1_q - p2_q);
      sum_neg = e1;
    end else begin
      sum_mag = SW'(p2_q - p1_q);
      sum_neg = e2;
    end
    if (sum_mag == '0) begin
      sum_neg = 1'b0;
    end
  end

  // Divider request per phase
  always_comb begin
    div_start = 1'b0;
    div_dvd   = x_q;
    div_dvs   = y_q;
    case (state_q)
      rau_pkg::S_GCD_START: div_start = (y_q != '0);
      rau_pkg::S_DIVN_START: begin
        div_start = 1'b1;
        div_dvd   = num_q;
        div_dvs   = x_q;
      end
      rau_pkg::S_DIVD_START: begin
        div_start = 1'b1;
        div_dvd   = den_q;
        div_dvs   = x_q;
      end
      default: ;
    endcase
  end

  rau_divider #(.Width(SW)) u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quo),
    .rem_o      (div_rem)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rau_pkg::S_IDLE: if (accept) state_d = rau_pkg::S_MUL1;
      rau_pkg::S_MUL1: begin
        if (mode_q > rau_pkg::MODE_CMP || ad_q == '0 || bd_q == '0) begin
          state_d = rau_pkg::S_FIN;
        end else begin
          state_d = rau_pkg::S_MUL2;
        end
      end
      rau_pkg::S_MUL2: begin
        case (mode_q)
          rau_pkg::MODE_ADD, rau_pkg::MODE_SUB: state_d = rau_pkg::S_MUL3;
          rau_pkg::MODE_CMP:                    state_d = rau_pkg::S_FIN;
          default:                              state_d = rau_pkg::S_REDUCE;
        endcase
      end
      rau_pkg::S_MUL3: state_d = rau_pkg::S_REDUCE;
      rau_pkg::S_REDUCE: begin
        if (den_q == '0 || num_q == '0) begin
          state_d = rau_pkg::S_FIN;
        end else begin
          state_d = rau_pkg::S_GCD_START;
        end
      end
      rau_pkg::S_GCD_START: begin
        state_d = (y_q == '0) ? rau_pkg::S_DIVN_START : rau_pkg::S_GCD_WAIT;
      end
      rau_pkg::S_GCD_WAIT:   if (div_done) state_d = rau_pkg::S_GCD_START;
      rau_pkg::S_DIVN_START: state_d = rau_pkg::S_DIVN_WAIT;
      rau_pkg::S_DIVN_WAIT:  if (div_done) state_d = rau_pkg::S_DIVD_START;
      rau_pkg::S_DIVD_START: state_d = rau_pkg::S_DIVD_WAIT;
      rau_pkg::S_DIVD_WAIT:  if (div_done) state_d = rau_pkg::S_CHECK;
      rau_pkg::S_CHECK:      state_d = rau_pkg::S_FIN;
      rau_pkg::S_FIN:        if (out_free) state_d = rau_pkg::S_IDLE;
      default:               state_d = rau_pkg::S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_stall_o  = (state_q != rau_pkg::S_IDLE);
    out_valid_o = out_valid_q;
    out_data_o  = out_q;
  end

  assign n_ext = rau_pkg::NumW'(n_q[ValueW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rau_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == rau_pkg::S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == rau_pkg::S_FIN && out_free) begin
      out_q <= res_q;
    end
    case (state_q)
      rau_pkg::S_IDLE: begin
        if (accept) begin
          mode_q       <= in_data_i.mode;
          {ans_q, an_q} <= to_sm(in_data_i.a_num);
          {ads_q, ad_q} <= to_sm(in_data_i.a_den);
          {bns_q, bn_q} <= to_sm(in_data_i.b_num);
          {bds_q, bd_q} <= to_sm(in_data_i.b_den);
        end
      end
      rau_pkg::S_MUL1: begin
        p1_q  <= prod;
        s1_q  <= mul_s;
        res_q <= '0;
        if (mode_q <= rau_pkg::MODE_CMP && (ad_q == '0 || bd_q == '0)) begin
          res_q.status <= rau_pkg::ST_ZERO_DEN;
        end
      end
      rau_pkg::S_MUL2: begin
        p2_q <= prod;
        s2_q <= mul_s;
        if (mode_q == rau_pkg::MODE_CMP) begin
          res_q.equal <= (p1_q == prod) && ((e1) == (mul_s && prod != '0));
        end else begin
          num_q <= SW'(p1_q);
          neg_q <= e1 ^ (mul_s && prod != '0);
          den_q <= SW'(prod);
        end
      end
      rau_pkg::S_MUL3: begin
        // Fold the sign of the denominator product into the result sign
        num_q <= sum_mag;
        neg_q <= sum_neg ^ mul_s;
        den_q <= SW'(prod);
      end
      rau_pkg::S_REDUCE: begin
        x_q <= num_q;
        y_q <= den_q;
        if (den_q == '0) begin
          res_q.status <= rau_pkg::ST_ZERO_DEN;
        end else if (num_q == '0) begin
          res_q.res_den <= rau_pkg::DenW'(1);
        end
      end
      rau_pkg::S_GCD_WAIT: begin
        if (div_done) begin
          x_q <= y_q;
          y_q <= div_rem;
        end
      end
      rau_pkg::S_DIVN_WAIT: if (div_done) n_q <= div_quo;
      rau_pkg::S_DIVD_WAIT: if (div_done) d_q <= div_quo;
      rau_pkg::S_CHECK: begin
        if (d_q >= Limit || n_q > (neg_q ? Limit : Limit - 1'b1)) begin
          res_q.status <= rau_pkg::ST_OVERFLOW;
        end else begin
          res_q.res_num <= neg_q ? (~n_ext + 1'b1) : n_ext;
          res_q.res_den <= rau_pkg::DenW'(d_q[ValueW-2:0]);
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/rau_checker.sv =====
module rau_assert (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input rau_pkg::out_t out_data_o
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Status code stays in its defined set
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= rau_pkg::ST_OVERFLOW)
    else $error("undefined status");

  // Error results carry zero fraction
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != rau_pkg::ST_OK
      |-> out_data_o.res_num == '0 && out_data_o.res_den == '0 && !out_data_o.equal)
    else $error("error result not cleared");

  // Equal flag only on a clean compare result
  a_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.equal
      |-> out_data_o.res_num == '0 && out_data_o.res_den == '0)
    else $error("equal with nonzero fraction");

endmodule

bind rational_arithmetic_unit rau_assert u_rau_assert (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
